### sv/bitmap_block_allocator_macros.svh
// Assertion macros shared by the bitmap block allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
`default_nettype none

package bba_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned MAX_BLOCKS_DEF    = 4096;
  localparam int unsigned BITS_PER_WORD_DEF = 64;

  // Fixed field widths
  localparam int unsigned BLK_W    = 12;
  localparam int unsigned TOTAL_W  = 13;
  localparam int unsigned STATUS_W = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOTUSED = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  // One result beat from the controller
  typedef struct packed {
    logic             done;
    logic [BLK_W-1:0] granted;
    status_e          status;
  } result_t;

endpackage

`default_nettype wire

### sv/bba_bitmap_ram.sv
// Used-bit bitmap memory: one write port, one registered read port.
`default_nettype none

module bba_bitmap_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one word, data valid the next cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/bba_ctrl.sv
// Allocator controller: clearing pass, first-fit word scan and free read-modify-write.
`default_nettype none
`include "bitmap_block_allocator_macros.svh"

module bba_ctrl #(
  parameter int unsigned BITS_PER_WORD = 64,
  parameter int unsigned WORDS         = 64,
  parameter int unsigned WORD_W        = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          kind_i,
  input  logic [bba_pkg::BLK_W-1:0]     blk_i,
  input  logic [bba_pkg::TOTAL_W-1:0]   limit_i,
  output logic                          mem_we_o,
  output logic [WORD_W-1:0]             mem_waddr_o,
  output logic [BITS_PER_WORD-1:0]      mem_wdata_o,
  output logic                          mem_re_o,
  output logic [WORD_W-1:0]             mem_raddr_o,
  input  logic [BITS_PER_WORD-1:0]      mem_rdata_i,
  output bba_pkg::result_t              result_o
);

  import bba_pkg::*;

  localparam int unsigned BIT_W    = $clog2(BITS_PER_WORD);
  localparam int unsigned BASE_W   = TOTAL_W + 1;
  // Reciprocal for block / BITS_PER_WORD, exact after one up-correction
  localparam int unsigned RECIP_SH = 24;
  localparam int unsigned RECIP    = (1 << RECIP_SH) / BITS_PER_WORD;
  localparam int unsigned RECIP_W  = RECIP_SH - 2;
  localparam int unsigned PROD_W   = BLK_W + RECIP_W;
  localparam int unsigned Q_W      = PROD_W - RECIP_SH;
  localparam logic [BITS_PER_WORD-1:0] ONE_W = BITS_PER_WORD'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FDIV,
    S_FCHK
  } state_e;

  state_e              state_q;
  logic [WORD_W-1:0]   clr_q;
  logic [WORD_W-1:0]   word_q;
  logic [BASE_W-1:0]   base_q;
  logic [BLK_W-1:0]    blk_q;
  logic [PROD_W-1:0]   prod_q;
  logic [BIT_W-1:0]    bit_q;
  result_t             res_q;
  result_t             res_d;

  logic [BASE_W-1:0]        rem;
  logic [BASE_W-1:0]        next_base;
  logic [BITS_PER_WORD-1:0] free_vec;
  logic                     ff_found;
  logic [BIT_W-1:0]         ff_idx;
  logic [Q_W-1:0]           q0;
  logic [BLK_W-1:0]         r0;
  logic                     r_over;
  logic [Q_W-1:0]           q_fix;
  logic [BLK_W-1:0]         r_fix;

  // Mask off blocks at or beyond the limit in the current word
  assign rem       = BASE_W'(limit_i) - base_q;
  assign next_base = base_q + BASE_W'(BITS_PER_WORD);

  always_comb begin
    for (int b = 0; b < BITS_PER_WORD; b++) begin
      free_vec[b] = ~mem_rdata_i[b] & (BASE_W'(b) < rem);
    end
  end

  // Find the lowest free bit
  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int b = BITS_PER_WORD - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        ff_found = 1'b1;
        ff_idx   = BIT_W'(b);
      end
    end
  end

  // Split the freed block into word and bit, correcting the reciprocal estimate
  assign q0     = prod_q[PROD_W-1 -: Q_W];
  assign r0     = blk_q - BLK_W'(q0 * BITS_PER_WORD);
  assign r_over = (r0 >= BLK_W'(BITS_PER_WORD));
  assign q_fix  = r_over ? q0 + 1'b1 : q0;
  assign r_fix  = r_over ? r0 - BLK_W'(BITS_PER_WORD) : r0;

  // Drive the memory ports
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = word_q;
    mem_wdata_o = mem_rdata_i | (ONE_W << ff_idx);
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
      end
      S_IDLE: begin
        if (start_i && kind_i == KIND_ALLOC && limit_i != '0) begin
          mem_re_o = 1'b1;
        end
      end
      S_SCAN: begin
        if (ff_found) begin
          mem_we_o = 1'b1;
        end else if (next_base < BASE_W'(limit_i)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = word_q + 1'b1;
        end
      end
      S_FDIV: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = WORD_W'(q_fix);
      end
      S_FCHK: begin
        mem_we_o    = mem_rdata_i[bit_q];
        mem_wdata_o = mem_rdata_i & ~(ONE_W << bit_q);
      end
      default: ;
    endcase
  end

  // Form the result beat for the coming edge
  always_comb begin
    res_d = '{done: 1'b0, granted: '0, status: ST_OK};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_ALLOC) begin
            if (limit_i == '0) begin
              res_d = '{done: 1'b1, granted: '0, status: ST_NOSPACE};
            end
          end else if (TOTAL_W'(blk_i) >= limit_i) begin
            res_d = '{done: 1'b1, granted: '0, status: ST_RANGE};
          end
        end
      end
      S_SCAN: begin
        if (ff_found) begin
          res_d = '{done: 1'b1, granted: BLK_W'(base_q + BASE_W'(ff_idx)),
                    status: ST_OK};
        end else if (next_base >= BASE_W'(limit_i)) begin
          res_d = '{done: 1'b1, granted: '0, status: ST_NOSPACE};
        end
      end
      S_FCHK: begin
        if (mem_rdata_i[bit_q]) begin
          res_d = '{done: 1'b1, granted: '0, status: ST_OK};
        end else begin
          res_d = '{done: 1'b1, granted: '0, status: ST_NOTUSED};
        end
      end
      default: ;
    endcase
  end

  // Hold state, datapath registers and the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      word_q  <= '0;
      base_q  <= '0;
      blk_q   <= '0;
      prod_q  <= '0;
      bit_q   <= '0;
      res_q   <= '0;
    end else begin
      res_q <= res_d;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == WORD_W'(WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            blk_q  <= blk_i;
            prod_q <= PROD_W'(blk_i * RECIP_W'(RECIP));
            base_q <= '0;
            word_q <= '0;
            if (kind_i == KIND_ALLOC) begin
              if (limit_i != '0) begin
                state_q <= S_SCAN;
              end
            end else if (TOTAL_W'(blk_i) < limit_i) begin
              state_q <= S_FDIV;
            end
          end
        end
        S_SCAN: begin
          if (ff_found) begin
            state_q <= S_IDLE;
          end else if (next_base < BASE_W'(limit_i)) begin
            base_q <= next_base;
            word_q <= word_q + 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FDIV: begin
          word_q  <= WORD_W'(q_fix);
          bit_q   <= BIT_W'(r_fix);
          state_q <= S_FCHK;
        end
        S_FCHK: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign result_o = res_q;

  `BBA_ASSERT_IMP(a_done_idle, res_q.done, state_q == S_IDLE, "result beat while not idle")
  `BBA_ASSERT_IMP(a_we_state, mem_we_o, state_q == S_CLEAR || state_q == S_SCAN || state_q == S_FCHK, "bitmap write outside a write state")
  `BBA_ASSERT_IMP(a_scan_base, state_q == S_SCAN, base_q < BASE_W'(limit_i), "scan word beyond block limit")
  `BBA_ASSERT_NXT(a_grant_ok, state_q == S_SCAN && ff_found, res_q.done && res_q.status == ST_OK, "found free block not granted")
  `BBA_ASSERT_IMP(a_grant_zero, res_q.done && res_q.status != ST_OK, res_q.granted == '0, "nonzero block on failed beat")

endmodule

`default_nettype wire

### sv/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------
//  command   start, busy          kind_i, block_number_i
//  result    done_o (one cycle)   granted_block_o, status_o
//  config    cfg_we_i             cfg_wdata_i (total_blocks)
//
// Allocate: the command beat issues the first read, then one bitmap word per cycle,
//   up to ceil(limit / BITS_PER_WORD) words.
// Free: reciprocal multiply, word split, then read-modify-write.
// Out-of-range free or a zero limit: result the cycle after the command beat.
// After reset a clearing pass writes all WORDS words with busy high. The bitmap
//   memory's single read port sets the scan rate.
`default_nettype none

module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS    = bba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned BITS_PER_WORD = bba_pkg::BITS_PER_WORD_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           kind_i,
  input  logic [bba_pkg::BLK_W-1:0]      block_number_i,
  input  logic                           cfg_we_i,
  input  logic [bba_pkg::TOTAL_W-1:0]    cfg_wdata_i,
  output logic                           done_o,
  output logic [bba_pkg::BLK_W-1:0]      granted_block_o,
  output logic [bba_pkg::STATUS_W-1:0]   status_o
);

  import bba_pkg::*;

  localparam int unsigned WORDS     = (MAX_BLOCKS + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int unsigned WORD_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CAP_LIMIT = (MAX_BLOCKS < (1 << TOTAL_W)) ? MAX_BLOCKS
                                                                    : (1 << TOTAL_W) - 1;

  logic [TOTAL_W-1:0]       total_q;
  logic [TOTAL_W-1:0]       limit;
  logic                     mem_we;
  logic [WORD_W-1:0]        mem_waddr;
  logic [BITS_PER_WORD-1:0] mem_wdata;
  logic                     mem_re;
  logic [WORD_W-1:0]        mem_raddr;
  logic [BITS_PER_WORD-1:0] mem_rdata;
  result_t                  result;

  // Hold the total block count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RESET;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // Clamp the total to the bitmap capacity
  assign limit = (total_q > TOTAL_W'(CAP_LIMIT)) ? TOTAL_W'(CAP_LIMIT) : total_q;

  bba_bitmap_ram #(
    .WIDTH (BITS_PER_WORD),
    .DEPTH (WORDS),
    .AW    (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bba_ctrl #(
    .BITS_PER_WORD (BITS_PER_WORD),
    .WORDS         (WORDS),
    .WORD_W        (WORD_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .kind_i      (kind_i),
    .blk_i       (block_number_i),
    .limit_i     (limit),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .result_o    (result)
  );

  // Drive the result beat
  assign done_o          = result.done;
  assign granted_block_o = result.granted;
  assign status_o        = result.status;

endmodule

`default_nettype wire
